/* hdl/ssd_pkg.sv */
// Shared constants for the stick sector decoder.
// Holds register indexes, output widths and the tangent limits of the ratio test.
// No dependencies.
`default_nettype none

package ssd_pkg;

	// default sample width of one stick axis
	localparam int SSD_AXIS_BITS = 8;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd2;
	localparam int DEAD_ZONE_RESET = 40;

	// result word
	localparam int SECTOR_W = 5;
	localparam int QUAD_W   = 2;
	localparam int STEP_W   = 2;

	// ratio test: minor * RATIO_ONE < (limit + 1) * major
	localparam int RATIO_W    = 14;
	localparam int RATIO_ONE  = 10000;
	localparam int NUM_LIMITS = 3;
	localparam int TAN_LIMIT [NUM_LIMITS] = '{1989, 4142, 6682};

endpackage : ssd_pkg

`default_nettype wire

/* hdl/ssd_cfg_regs.sv */
// Configuration registers of the stick sector decoder: center x, center y, dead zone.
// Depends on ssd_pkg for register indexes and reset values.
`default_nettype none

module ssd_cfg_regs import ssd_pkg::*; #(
	parameter int AXIS_BITS = SSD_AXIS_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [AXIS_BITS:0]   cfg_data,
	output logic      [AXIS_BITS-1:0] center_x,
	output logic      [AXIS_BITS-1:0] center_y,
	output logic      [AXIS_BITS:0]   dead_zone
);

	logic [AXIS_BITS-1:0] center_x_q;
	logic [AXIS_BITS-1:0] center_y_q;
	logic [AXIS_BITS:0]   dead_zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= AXIS_BITS'(1) << (AXIS_BITS - 1);
			center_y_q  <= AXIS_BITS'(1) << (AXIS_BITS - 1);
			dead_zone_q <= (AXIS_BITS + 1)'(DEAD_ZONE_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CENTER_X:  center_x_q  <= cfg_data[AXIS_BITS-1:0];
				CFG_CENTER_Y:  center_y_q  <= cfg_data[AXIS_BITS-1:0];
				CFG_DEAD_ZONE: dead_zone_q <= cfg_data;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	assign center_x  = center_x_q;
	assign center_y  = center_y_q;
	assign dead_zone = dead_zone_q;

endmodule : ssd_cfg_regs

`default_nettype wire

/* hdl/ssd_sector_calc.sv */
// Combinational sector decode of one stick sample: dead zone, quadrant, octant, ratio step.
// Depends on ssd_pkg for widths and the tangent limits.
`default_nettype none

module ssd_sector_calc import ssd_pkg::*; #(
	parameter int AXIS_BITS = SSD_AXIS_BITS
) (
	input  wire logic [AXIS_BITS-1:0] x,
	input  wire logic [AXIS_BITS-1:0] y,
	input  wire logic [AXIS_BITS-1:0] center_x,
	input  wire logic [AXIS_BITS-1:0] center_y,
	input  wire logic [AXIS_BITS:0]   dead_zone,
	output logic      [SECTOR_W-1:0]  sector,
	output logic                      active
);

	localparam int PROD_W = AXIS_BITS + RATIO_W;

	logic [AXIS_BITS-1:0]  dx;
	logic [AXIS_BITS-1:0]  dy;
	logic [AXIS_BITS:0]    manhattan;
	logic                  left;
	logic                  top;
	logic [AXIS_BITS-1:0]  minor;
	logic [AXIS_BITS-1:0]  major;
	logic [PROD_W-1:0]     minor_scaled;
	logic [NUM_LIMITS-1:0] hit;
	logic [STEP_W-1:0]     step;
	logic [QUAD_W-1:0]     quad;
	logic                  ascending;

	always_comb begin
		dx = (x >= center_x) ? x - center_x : center_x - x;
		dy = (y >= center_y) ? y - center_y : center_y - y;
		manhattan = {1'b0, dx} + {1'b0, dy};
		active    = manhattan > dead_zone;
		left   = x <= center_x;
		top    = y <= center_y;

		// quadrants clockwise from left-top
		quad = {~top, left ^ top};

		minor = (dx <= dy) ? dx : dy;
		major = (dx <= dy) ? dy : dx;

		// cross-multiplied threshold test against each tangent limit
		minor_scaled = PROD_W'(minor) * PROD_W'(RATIO_ONE);
		for (int i = 0; i < NUM_LIMITS; i++) begin
			hit[i] = minor_scaled < PROD_W'(major) * PROD_W'(TAN_LIMIT[i] + 1);
		end

		if (hit[0])      step = STEP_W'(0);
		else if (hit[1]) step = STEP_W'(1);
		else if (hit[2]) step = STEP_W'(2);
		else             step = STEP_W'(3);

		// first half of a quadrant counts up, second half counts down from its end
		ascending = quad[0] ? (dx <= dy) : (dx >= dy);

		if (active) begin
			sector = ascending ? {quad, 1'b0, step} : {quad, 1'b1, ~step};
		end else begin
			sector = '0;
		end
	end

endmodule : ssd_sector_calc

`default_nettype wire

/* hdl/stick_sector_decoder_top.sv */
// Top level of the stick sector decoder: input register, sector decode, result register.
// Depends on ssd_pkg, ssd_cfg_regs and ssd_sector_calc.
//
// Use: one sample (stick_x, stick_y) per word on the input channel, one word
// (sector, active) per sample on the output channel. Both channels hand over a
// word at a rising edge where valid is high and stall is low.
// The decode sits between the input register and the result register, so an
// accepted word is held in the input register and then in the result register
// before it can leave on the output channel.
// Throughput: one sample per cycle, sustained as long as out_stall stays low.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more sample; in_stall rises only once both are full.
// Reset clears both valid flags and loads the default center (half scale) and
// a dead zone of 40. Configuration writes take effect at the next edge; the
// user must make them while no sample is in flight; the block does not enforce it.
// sector counts clockwise from left-up in steps of 11.25 degrees; inside the
// dead zone active is 0 and sector is 0.
`default_nettype none

module stick_sector_decoder_top import ssd_pkg::*; #(
	parameter int AXIS_BITS = SSD_AXIS_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [AXIS_BITS:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [AXIS_BITS-1:0] stick_x,
	input  wire logic [AXIS_BITS-1:0] stick_y,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [SECTOR_W-1:0]  sector,
	output logic                      active
);

	logic [AXIS_BITS-1:0] center_x;
	logic [AXIS_BITS-1:0] center_y;
	logic [AXIS_BITS:0]   dead_zone;

	logic                 valid_s1;
	logic [AXIS_BITS-1:0] x_s1;
	logic [AXIS_BITS-1:0] y_s1;
	logic                 valid_s2;
	logic [SECTOR_W-1:0]  sector_s2;
	logic                 active_s2;

	logic [SECTOR_W-1:0]  sector_calc;
	logic                 active_calc;
	logic                 load_s1;
	logic                 load_s2;

	ssd_cfg_regs #(
		.AXIS_BITS(AXIS_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.center_x  (center_x),
		.center_y  (center_y),
		.dead_zone (dead_zone)
	);

	ssd_sector_calc #(
		.AXIS_BITS(AXIS_BITS)
	) u_calc (
		.x         (x_s1),
		.y         (y_s1),
		.center_x  (center_x),
		.center_y  (center_y),
		.dead_zone (dead_zone),
		.sector    (sector_calc),
		.active    (active_calc)
	);

	// result stage frees up when empty or when its word leaves
	assign load_s2  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			x_s1 <= stick_x;
			y_s1 <= stick_y;
		end
		if (load_s2 && valid_s1) begin
			sector_s2 <= sector_calc;
			active_s2 <= active_calc;
		end
	end

	assign out_valid = valid_s2;
	assign sector    = sector_s2;
	assign active    = active_s2;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while a stage was free");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (!valid_s2 || !out_stall)) |=> out_valid)
		else $error("word in the input register was not moved to the result register");

	a_inactive_sector_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !active) |-> (sector == '0))
		else $error("inactive result carries a nonzero sector");
`endif

endmodule : stick_sector_decoder_top

`default_nettype wire
